FILE: hdl/pntg_pkg.sv
// Shared types, constants and fixed-point helpers of the procedural texel generator.
`default_nettype none

package pntg_pkg;

    localparam int TEX_SIZE_DEF = 64;

    localparam logic [2:0] KIND_STONE = 3'd0;
    localparam logic [2:0] KIND_TILE  = 3'd1;
    localparam logic [2:0] KIND_WOOD  = 3'd2;
    localparam logic [2:0] KIND_METAL = 3'd3;
    localparam logic [2:0] KIND_FLESH = 3'd4;

    localparam logic [31:0] HASH_X = 32'd374761393;
    localparam logic [31:0] HASH_Y = 32'd668265263;
    localparam logic [31:0] HASH_S = 32'd982451653;
    localparam logic [31:0] HASH_M = 32'd1274126177;

    localparam logic [6:0] SEED_GRAIN   = 7'd99;
    localparam logic [6:0] SEED_SCRATCH = 7'd5;
    localparam logic [6:0] SEED_VEIN    = 7'd31;
    localparam logic [6:0] SEED_STAIN   = 7'd77;

    localparam logic [17:0] QMAX  = 18'h3FFFF;
    localparam logic [16:0] Q_ONE = 17'd65536;

    typedef struct packed {
        logic [2:0] texture_kind;
        logic [5:0] pixel_x;
        logic [5:0] pixel_y;
    } pntg_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pntg_out_t;

    // lattice corners and blend fractions of one value-noise lookup
    typedef struct packed {
        logic [3:0]  x0;
        logic [3:0]  x1;
        logic [3:0]  y0;
        logic [3:0]  y1;
        logic [6:0]  seed;
        logic [15:0] tx;
        logic [15:0] ty;
    } vn_in_t;

    function automatic logic [15:0] rmul16(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] p;
        p = 33'(a) * 33'(b) + 33'd32768;
        return p[31:16];
    endfunction

    function automatic logic [16:0] smooth_fin(input logic [15:0] t2, input logic [15:0] t3);
        logic [17:0] s;
        s = 18'(t2) * 18'd3 - 18'(t3) * 18'd2;
        return s[16:0];
    endfunction

    function automatic logic [16:0] lerpq(input logic [16:0] a, input logic [16:0] b,
                                          input logic [16:0] t);
        logic [34:0] p;
        p = 35'(a) * 35'(Q_ONE - t) + 35'(b) * 35'(t) + 35'd32768;
        return p[32:16];
    endfunction

    function automatic logic [17:0] mulq(input logic [17:0] a, input logic [16:0] c);
        logic [34:0] p;
        p = 35'(a) * 35'(c) + 35'd32768;
        return p[34] ? QMAX : p[33:16];
    endfunction

    function automatic logic [17:0] addq(input logic [17:0] a, input logic [17:0] b);
        logic [18:0] s;
        s = 19'(a) + 19'(b);
        return s[18] ? QMAX : s[17:0];
    endfunction

    function automatic logic [7:0] level(input logic [17:0] c);
        logic [16:0] cc;
        logic [21:0] p;
        cc = (c > 18'(Q_ONE)) ? Q_ONE : c[16:0];
        p = 22'(cc) * 22'd31;
        return {p[20:16], 3'b000};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/procedural_noise_texel_generator_core.sv
// Top level of the procedural noise texel generator pipeline.
//
// Usage: present a texel request on req (texture_kind, pixel_x, pixel_y) with
// req_valid; it is taken at a clock edge where req_valid and req_ready are both
// high. The finished texel appears on pix with pix_valid and is taken at an
// edge where pix_valid and pix_ready are both high.
// The datapath is an 11-stage pipeline: hashes, smoothstep, lerps, fBm sum,
// per-kind shaping and color quantization each own their stages. An
// accepted word passes through every stage before it can be taken from pix.
// Throughput is one texel per clock while pix_ready stays high.
// When pix_ready is low the words stay in place; empty stages still fill, so
// req_ready stays high until every stage holds a word.
// Reset clears only the stage valid bits; the block needs no setup and is
// ready in the first cycle after reset.
`default_nettype none

module procedural_noise_texel_generator_core #(
    parameter int TEX_SIZE = pntg_pkg::TEX_SIZE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire pntg_pkg::pntg_in_t   req,
    output logic                      pix_valid,
    input  wire logic                 pix_ready,
    output pntg_pkg::pntg_out_t       pix
);
    import pntg_pkg::*;

    localparam int STAGES = 11;

    // lattice periods; coordinates never pass 12, so a period above 16 acts as 16
    localparam int N32_RAW = TEX_SIZE / 32;
    localparam int N16_RAW = TEX_SIZE / 16;
    localparam int N8_RAW  = TEX_SIZE / 8;
    localparam int NW_RAW  = (TEX_SIZE * 6) / 32;
    localparam int N32 = (N32_RAW < 1) ? 1 : ((N32_RAW > 16) ? 16 : N32_RAW);
    localparam int N16 = (N16_RAW < 1) ? 1 : ((N16_RAW > 16) ? 16 : N16_RAW);
    localparam int N8  = (N8_RAW  < 1) ? 1 : ((N8_RAW  > 16) ? 16 : N8_RAW);
    localparam int NW  = (NW_RAW  < 1) ? 1 : ((NW_RAW  > 16) ? 16 : NW_RAW);

    typedef struct packed {
        logic [2:0] kind;
        logic       mortar;
        logic       tline;
        logic       rivet;
        logic       scratch;
        logic       vein;
        logic       stain;
    } ctl_t;

    logic [STAGES+1:1] ce;
    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vprev;

    ctl_t        ctl_reg [1:9];
    vn_in_t      vn_reg  [4];
    vn_in_t      vn_next [4];
    logic [5:0]  scr_x_reg;
    logic [3:0]  scr_y_reg;
    logic [16:0] scr_lat;
    logic [16:0] nval [4];

    logic [16:0] fbm_reg;
    logic [16:0] ext_reg;
    logic [17:0] v8_reg;
    logic [17:0] v9_reg;
    logic [17:0] r_reg;
    logic [17:0] g_reg;
    logic [17:0] b_reg;
    pntg_out_t   out_reg;

    // remainder of a small lattice index by the period
    function automatic logic [3:0] wrap(input logic [4:0] i, input logic [4:0] n);
        logic [8:0] r;
        logic [8:0] d;
        r = 9'(i);
        for (int k = 3; k >= 0; k--)
        begin
            d = 9'(n) << k;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[3:0];
    endfunction

    function automatic vn_in_t mk_vn(input logic [3:0] ix, input logic [15:0] tx,
                                     input logic [3:0] iy, input logic [15:0] ty,
                                     input logic [4:0] n, input logic [6:0] seed);
        vn_in_t v;
        v.x0   = wrap(5'(ix), n);
        v.x1   = wrap(5'(ix) + 5'd1, n);
        v.y0   = wrap(5'(iy), n);
        v.y1   = wrap(5'(iy) + 5'd1, n);
        v.seed = seed;
        v.tx   = tx;
        v.ty   = ty;
        return v;
    endfunction

    // stall chain: a stage loads when it is empty or its word moves on
    always_comb
    begin
        ce[STAGES+1] = pix_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            ce[k] = !vld_reg[k] || ce[k+1];
        end
    end

    assign vprev     = {vld_reg[STAGES-1:1], req_valid};
    assign req_ready = ce[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= STAGES; k++)
            begin
                if (ce[k])
                begin
                    vld_reg[k] <= vprev[k];
                end
            end
        end
    end

    // stage 1: lattice corners and fractions for the octaves and the kind's extra noise
    always_comb
    begin
        logic [6:0] fs;
        logic [8:0] xs;
        fs = 7'(req.texture_kind) * 7'd13 + 7'd7;
        xs = 9'(req.pixel_x) * 9'd6;
        vn_next[0] = mk_vn({3'b000, req.pixel_x[5]}, {req.pixel_x[4:0], 11'b0},
                           {3'b000, req.pixel_y[5]}, {req.pixel_y[4:0], 11'b0},
                           5'(N32), fs);
        vn_next[1] = mk_vn({2'b00, req.pixel_x[5:4]}, {req.pixel_x[3:0], 12'b0},
                           {2'b00, req.pixel_y[5:4]}, {req.pixel_y[3:0], 12'b0},
                           5'(N16), fs + 7'd1);
        vn_next[2] = mk_vn({1'b0, req.pixel_x[5:3]}, {req.pixel_x[2:0], 13'b0},
                           {1'b0, req.pixel_y[5:3]}, {req.pixel_y[2:0], 13'b0},
                           5'(N8), fs + 7'd2);
        case (req.texture_kind)
            KIND_WOOD:
            begin
                vn_next[3] = mk_vn(xs[8:5], {xs[4:0], 11'b0},
                                   {3'b000, req.pixel_y[5]}, {req.pixel_y[4:0], 11'b0},
                                   5'(NW), SEED_GRAIN);
            end
            KIND_FLESH:
            begin
                vn_next[3] = mk_vn({1'b0, req.pixel_x[5:3]}, {req.pixel_x[2:0], 13'b0},
                                   {1'b0, req.pixel_y[5:3]}, {req.pixel_y[2:0], 13'b0},
                                   5'(N8), SEED_VEIN);
            end
            default:
            begin
                vn_next[3] = mk_vn({2'b00, req.pixel_x[5:4]}, {req.pixel_x[3:0], 12'b0},
                                   {2'b00, req.pixel_y[5:4]}, {req.pixel_y[3:0], 12'b0},
                                   5'(N16), SEED_STAIN);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        logic [6:0] msum;
        ctl_t       cn;
        msum = 7'(req.pixel_x) + {2'b00, req.pixel_y[4], 4'b0000};
        if (ce[1])
        begin
            for (int i = 0; i < 4; i++)
            begin
                vn_reg[i] <= vn_next[i];
            end
            scr_x_reg          <= req.pixel_x;
            scr_y_reg          <= req.pixel_y[5:2];
            ctl_reg[1].kind    <= req.texture_kind;
            ctl_reg[1].mortar  <= (msum[4:1] == 4'd0) || (req.pixel_y[3:1] == 3'd0);
            ctl_reg[1].tline   <= (req.pixel_x[3:0] == 4'd0) || (req.pixel_y[3:0] == 4'd0);
            ctl_reg[1].rivet   <= (req.pixel_x[4:0] < 5'd3) && (req.pixel_y[4:0] < 5'd3);
            ctl_reg[1].scratch <= 1'b0;
            ctl_reg[1].vein    <= 1'b0;
            ctl_reg[1].stain   <= 1'b0;
        end
        // scratch joins at stage 5, vein and stain at stage 8
        for (int k = 2; k <= 9; k++)
        begin
            if (ce[k])
            begin
                cn = ctl_reg[k-1];
                if (k == 5)
                begin
                    cn.scratch = scr_lat > 17'd60948;
                end
                if (k == 8)
                begin
                    cn.vein  = ext_reg > 17'd45875;
                    cn.stain = ext_reg > 17'd49152;
                end
                ctl_reg[k] <= cn;
            end
        end
    end

    // stages 2..6: noise lookups
    for (genvar i = 0; i < 4; i++)
    begin : g_noise
        pntg_vnoise u_vnoise (
            .clk (clk),
            .ce  (ce[6:2]),
            .vn  (vn_reg[i]),
            .val (nval[i])
        );
    end

    pntg_hash u_scratch (
        .clk  (clk),
        .ce   (ce[4:2]),
        .hx   (scr_x_reg),
        .hy   ({2'b00, scr_y_reg}),
        .seed (SEED_SCRATCH),
        .lat  (scr_lat)
    );

    // stages 7..11: fBm sum, per-kind shaping, tint, quantize
    logic [17:0] base8;
    logic [16:0] c1_8;
    logic [16:0] c2_8;
    logic        mul9;
    logic [16:0] cm9;
    logic [17:0] scr9;
    logic [17:0] riv9;
    logic [16:0] rc10;
    logic [16:0] gc10;
    logic [16:0] bc10;

    always_comb
    begin
        c2_8 = 17'd0;
        case (ctl_reg[7].kind)
            KIND_STONE:
            begin
                base8 = 18'd27525;
                c1_8  = 17'd19661;
            end
            KIND_TILE:
            begin
                base8 = 18'd23593;
                c1_8  = 17'd16384;
            end
            KIND_WOOD:
            begin
                base8 = 18'd19661;
                c1_8  = 17'd6554;
                c2_8  = 17'd19661;
            end
            KIND_METAL:
            begin
                base8 = 18'd13107;
                c1_8  = 17'd9830;
            end
            KIND_FLESH:
            begin
                base8 = 18'd19661;
                c1_8  = 17'd22938;
            end
            default:
            begin
                base8 = 18'd36045;
                c1_8  = 17'd16384;
            end
        endcase
    end

    always_comb
    begin
        mul9 = 1'b0;
        cm9  = Q_ONE;
        scr9 = '0;
        riv9 = '0;
        case (ctl_reg[8].kind)
            KIND_STONE:
            begin
                mul9 = ctl_reg[8].mortar;
                cm9  = 17'd29491;
            end
            KIND_TILE:
            begin
                mul9 = ctl_reg[8].tline;
                cm9  = 17'd36045;
            end
            KIND_METAL:
            begin
                scr9 = ctl_reg[8].scratch ? 18'd9830 : 18'd0;
                riv9 = ctl_reg[8].rivet ? 18'd13107 : 18'd0;
            end
            KIND_WOOD, KIND_FLESH:
            begin
                mul9 = 1'b0;
            end
            default:
            begin
                mul9 = ctl_reg[8].stain;
                cm9  = 17'd45875;
            end
        endcase
    end

    // a tint of Q_ONE passes the level through unchanged
    always_comb
    begin
        case (ctl_reg[9].kind)
            KIND_STONE:
            begin
                rc10 = 17'd62259;
                gc10 = 17'd60948;
                bc10 = Q_ONE;
            end
            KIND_TILE:
            begin
                rc10 = 17'd55706;
                gc10 = 17'd58982;
                bc10 = Q_ONE;
            end
            KIND_WOOD:
            begin
                rc10 = Q_ONE;
                gc10 = 17'd45875;
                bc10 = 17'd29491;
            end
            KIND_METAL:
            begin
                rc10 = 17'd58982;
                gc10 = 17'd62259;
                bc10 = Q_ONE;
            end
            KIND_FLESH:
            begin
                rc10 = Q_ONE;
                gc10 = 17'd29491;
                bc10 = 17'd32768;
            end
            default:
            begin
                rc10 = Q_ONE;
                gc10 = 17'd63570;
                bc10 = 17'd58982;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        logic [33:0] fsum;
        fsum = {2'b00, nval[0], 15'b0} + 34'(nval[1]) * 34'd19661
             + 34'(nval[2]) * 34'd13107 + 34'd32768;
        if (ce[7])
        begin
            fbm_reg <= fsum[32:16];
            ext_reg <= nval[3];
        end
        if (ce[8])
        begin
            v8_reg <= addq(addq(base8, mulq(18'(ext_reg), c2_8)), mulq(18'(fbm_reg), c1_8));
        end
        if (ce[9])
        begin
            v9_reg <= mul9 ? mulq(v8_reg, cm9) : addq(addq(v8_reg, scr9), riv9);
        end
        if (ce[10])
        begin
            if (ctl_reg[9].kind == KIND_FLESH)
            begin
                r_reg <= addq(addq(v9_reg, 18'd13107), ctl_reg[9].vein ? 18'd9830 : 18'd0);
            end
            else
            begin
                r_reg <= mulq(v9_reg, rc10);
            end
            g_reg <= mulq(v9_reg, gc10);
            b_reg <= mulq(v9_reg, bc10);
        end
        if (ce[11])
        begin
            out_reg.red   <= level(r_reg);
            out_reg.green <= level(g_reg);
            out_reg.blue  <= level(b_reg);
        end
    end

    assign pix_valid = vld_reg[STAGES];
    assign pix       = out_reg;

    // a full, stalled pipeline must refuse new words
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !pix_ready |-> !req_ready)
        else $error("request taken while every stage is full and output stalled");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> vld_reg[1])
        else $error("accepted word did not enter the first stage");

    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[6] |-> nval[0] <= Q_ONE && nval[1] <= Q_ONE && nval[2] <= Q_ONE
                       && nval[3] <= Q_ONE)
        else $error("noise value above one");

endmodule

`default_nettype wire

FILE: hdl/pntg_hash.sv
// Three-stage pipelined 32-bit lattice hash giving a Q16 lattice value.
`default_nettype none

module pntg_hash (
    input  wire logic        clk,
    input  wire logic [2:0]  ce,
    input  wire logic [5:0]  hx,
    input  wire logic [5:0]  hy,
    input  wire logic [6:0]  seed,
    output logic      [16:0] lat
);
    import pntg_pkg::*;

    logic [31:0] mix_reg;
    logic [31:0] prod_reg;
    logic [16:0] lat_reg;
    logic [15:0] fold;

    assign fold = prod_reg[15:0] ^ prod_reg[31:16];

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            mix_reg <= 32'(hx) * HASH_X + 32'(hy) * HASH_Y + 32'(seed) * HASH_S;
        end
        if (ce[1])
        begin
            prod_reg <= (mix_reg ^ (mix_reg >> 13)) * HASH_M;
        end
        if (ce[2])
        begin
            // v*65537 rounded back to Q16 is v plus its top bit
            lat_reg <= 17'(fold) + 17'(fold[15]);
        end
    end

    assign lat = lat_reg;

endmodule

`default_nettype wire

FILE: hdl/pntg_vnoise.sv
// Pipelined value noise: four corner hashes, smoothstep weights and two lerp stages.
`default_nettype none

module pntg_vnoise (
    input  wire logic                 clk,
    input  wire logic [4:0]           ce,
    input  wire pntg_pkg::vn_in_t     vn,
    output logic      [16:0]          val
);
    import pntg_pkg::*;

    logic [16:0] lat [4];
    logic [3:0]  cx [4];
    logic [3:0]  cy [4];
    logic [15:0] tin [2];

    logic [15:0] t1_reg  [2];
    logic [15:0] sq_reg  [2];
    logic [15:0] sq2_reg [2];
    logic [15:0] cu_reg  [2];
    logic [16:0] s_reg   [2];
    logic [16:0] sy_reg;
    logic [16:0] top_reg;
    logic [16:0] bot_reg;
    logic [16:0] val_reg;

    assign cx[0] = vn.x0;
    assign cy[0] = vn.y0;
    assign cx[1] = vn.x1;
    assign cy[1] = vn.y0;
    assign cx[2] = vn.x0;
    assign cy[2] = vn.y1;
    assign cx[3] = vn.x1;
    assign cy[3] = vn.y1;
    assign tin[0] = vn.tx;
    assign tin[1] = vn.ty;

    for (genvar i = 0; i < 4; i++)
    begin : g_corner
        pntg_hash u_hash (
            .clk  (clk),
            .ce   (ce[2:0]),
            .hx   ({2'b00, cx[i]}),
            .hy   ({2'b00, cy[i]}),
            .seed (vn.seed),
            .lat  (lat[i])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (ce[0])
            begin
                t1_reg[i] <= tin[i];
                sq_reg[i] <= rmul16(tin[i], tin[i]);
            end
            if (ce[1])
            begin
                sq2_reg[i] <= sq_reg[i];
                cu_reg[i]  <= rmul16(sq_reg[i], t1_reg[i]);
            end
            if (ce[2])
            begin
                s_reg[i] <= smooth_fin(sq2_reg[i], cu_reg[i]);
            end
        end
        if (ce[3])
        begin
            top_reg <= lerpq(lat[0], lat[1], s_reg[0]);
            bot_reg <= lerpq(lat[2], lat[3], s_reg[0]);
            sy_reg  <= s_reg[1];
        end
        if (ce[4])
        begin
            val_reg <= lerpq(top_reg, bot_reg, sy_reg);
        end
    end

    assign val = val_reg;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Testbench of the procedural noise texel generator: predicted texels against the pipeline.
`default_nettype none

module testbench;
    import pntg_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    pntg_in_t req = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    pntg_out_t pix;

    pntg_out_t texel_q[$];
    int mismatches = 0;
    int accepted = 0;
    bit hold_off = 1'b0;
    bit calm = 1'b0;

    procedural_noise_texel_generator_core uut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] mix_hash(logic [31:0] x, logic [31:0] y, logic [31:0] s);
        logic [31:0] h;
        h = x * 32'd374761393 + y * 32'd668265263 + s * 32'd982451653;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        return h ^ (h >> 16);
    endfunction

    function automatic longint unsigned q_round(longint unsigned p);
        return (p + 64'd32768) >> 16;
    endfunction

    function automatic longint unsigned grid_val(longint unsigned x, longint unsigned y,
                                                 longint unsigned s);
        return q_round(64'(mix_hash(32'(x), 32'(y), 32'(s)) & 32'hffff) * 64'd65537);
    endfunction

    function automatic longint unsigned ease(longint unsigned t);
        longint unsigned t2, t3;
        t2 = q_round(t * t);
        t3 = q_round(t2 * t);
        return 3 * t2 - 2 * t3;
    endfunction

    function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                              longint unsigned t);
        return q_round(a * (65536 - t) + b * t);
    endfunction

    function automatic longint unsigned scale(longint unsigned a, longint unsigned c);
        longint unsigned r;
        r = q_round(a * c);
        return r > 64'h3FFFF ? 64'h3FFFF : r;
    endfunction

    function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
        return (a + b) > 64'h3FFFF ? 64'h3FFFF : a + b;
    endfunction

    function automatic longint unsigned value_noise(longint unsigned x, longint unsigned y,
            longint unsigned span, longint unsigned pitch, longint unsigned s);
        longint unsigned n, ix, iy, tx, ty, a, b, c, d;
        n = span / pitch;
        if (n == 0)
            n = 1;
        ix = x / pitch;
        iy = y / pitch;
        tx = ease(((x % pitch) << 16) / pitch);
        ty = ease(((y % pitch) << 16) / pitch);
        a = grid_val(ix % n, iy % n, s);
        b = grid_val((ix + 1) % n, iy % n, s);
        c = grid_val(ix % n, (iy + 1) % n, s);
        d = grid_val((ix + 1) % n, (iy + 1) % n, s);
        return blend(blend(a, b, tx), blend(c, d, tx), ty);
    endfunction

    function automatic logic [7:0] quantize(longint unsigned c);
        if (c > 65536)
            c = 65536;
        return 8'(((c * 31) >> 16) * 8);
    endfunction

    function automatic pntg_out_t predict_texel(pntg_in_t w);
        longint unsigned x, y, k, n, v, r, g, b, extra;
        pntg_out_t o;
        x = w.pixel_x;
        y = w.pixel_y;
        k = w.texture_kind;
        n = q_round(value_noise(x, y, 64, 32, 7 + 13 * k) * 32768
                  + value_noise(x, y, 64, 16, 8 + 13 * k) * 19661
                  + value_noise(x, y, 64, 8, 9 + 13 * k) * 13107);
        case (w.texture_kind)
            KIND_STONE:
            begin
                v = sum_sat(27525, scale(n, 19661));
                if (((x + ((y / 16) & 1) * 16) % 32) < 2 || (y % 16) < 2)
                    v = scale(v, 29491);
                r = scale(v, 62259); g = scale(v, 60948); b = v;
            end
            KIND_TILE:
            begin
                v = sum_sat(23593, scale(n, 16384));
                if ((x % 16) == 0 || (y % 16) == 0)
                    v = scale(v, 36045);
                r = scale(v, 55706); g = scale(v, 58982); b = v;
            end
            KIND_WOOD:
            begin
                extra = value_noise(x * 6, y, 384, 32, 99);
                v = sum_sat(sum_sat(19661, scale(extra, 19661)), scale(n, 6554));
                r = v; g = scale(v, 45875); b = scale(v, 29491);
            end
            KIND_METAL:
            begin
                extra = grid_val(x, y / 4, 5) > 60948 ? 9830 : 0;
                v = sum_sat(sum_sat(13107, scale(n, 9830)), extra);
                if ((x % 32) < 3 && (y % 32) < 3)
                    v = sum_sat(v, 13107);
                r = scale(v, 58982); g = scale(v, 62259); b = v;
            end
            KIND_FLESH:
            begin
                extra = value_noise(x, y, 64, 8, 31) > 45875 ? 9830 : 0;
                v = sum_sat(19661, scale(n, 22938));
                r = sum_sat(sum_sat(v, 13107), extra);
                g = scale(v, 29491); b = scale(v, 32768);
            end
            default:
            begin
                v = sum_sat(36045, scale(n, 16384));
                if (value_noise(x, y, 64, 16, 77) > 49152)
                    v = scale(v, 45875);
                r = v; g = scale(v, 63570); b = scale(v, 58982);
            end
        endcase
        o.red = quantize(r);
        o.green = quantize(g);
        o.blue = quantize(b);
        return o;
    endfunction

    // check each word taken from pix against the oldest prediction
    always @(posedge clk)
    begin
        pntg_out_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            if (texel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected texel %h", pix);
            end
            else
            begin
                want = texel_q.pop_front();
                if (pix.red !== want.red || pix.green !== want.green
                        || pix.blue !== want.blue)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("texel mismatch: expected %h got %h", want, pix);
                end
            end
        end
    end

    // receiver: random stalls, calm stretch, and a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_ready <= 1'b0;
        else if (hold_off)
            pix_ready <= 1'b0;
        else
            pix_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
    end

    initial
    begin
        repeat (200) @(posedge clk);
        wait (accepted >= 300);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
    end

    // valid stays high after a word is taken unless the next one idles first
    task automatic send_texel(pntg_in_t w, bit has_fixed, pntg_out_t fixed);
        while (!calm && $urandom_range(99) < 25)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        texel_q.push_back(has_fixed ? fixed : predict_texel(w));
        do
            @(posedge clk);
        while (!req_ready);
        accepted++;
    endtask

    typedef struct {
        pntg_in_t w;
        bit has_fixed;
        pntg_out_t fixed;
    } stim_row_t;

    stim_row_t rows[] = '{
        '{'{KIND_STONE, 6'd0, 6'd0}, 1'b0, '0},
        '{'{KIND_STONE, 6'd63, 6'd63}, 1'b0, '0},
        '{'{KIND_STONE, 6'd17, 6'd20}, 1'b0, '0},
        '{'{KIND_TILE, 6'd0, 6'd5}, 1'b0, '0},
        '{'{KIND_TILE, 6'd33, 6'd47}, 1'b0, '0},
        '{'{KIND_WOOD, 6'd0, 6'd63}, 1'b0, '0},
        '{'{KIND_WOOD, 6'd42, 6'd21}, 1'b0, '0},
        '{'{KIND_METAL, 6'd1, 6'd2}, 1'b0, '0},
        '{'{KIND_METAL, 6'd63, 6'd0}, 1'b0, '0},
        '{'{KIND_FLESH, 6'd10, 6'd30}, 1'b0, '0},
        '{'{KIND_FLESH, 6'd63, 6'd63}, 1'b0, '0},
        '{'{3'd5, 6'd21, 6'd42}, 1'b0, '0},
        '{'{3'd6, 6'd0, 6'd0}, 1'b0, '0},
        '{'{3'd7, 6'd63, 6'd63}, 1'b0, '0},
        '{'{3'd7, 6'd31, 6'd16}, 1'b0, '0}
    };

    initial
    begin
        pntg_in_t w;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_texel(rows[i].w, rows[i].has_fixed, rows[i].fixed);
        for (int i = 0; i < 1635; i++)
        begin
            if (i == 400)
                calm = 1'b1;
            if (i == 600)
                calm = 1'b0;
            if (i == 900)
            begin
                // let the pipeline drain completely before going on
                req_valid <= 1'b0;
                wait (texel_q.size() == 0);
                @(posedge clk);
            end
            w.texture_kind = 3'($urandom_range(7));
            w.pixel_x = 6'($urandom);
            w.pixel_y = 6'($urandom);
            send_texel(w, 1'b0, '0);
        end
        req_valid <= 1'b0;
        wait (texel_q.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
